// ===== hdl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and helpers for the sphere/frustum culling block.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned DIG_W = 17;   // multiplier digit width
  localparam int unsigned OPA_W = 68;   // wide operand width
  localparam int unsigned ACC_W = 137;  // signed accumulator width
  localparam logic [2:0] PLANE_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_R2,
    S_PLN,
    S_SDOT,
    S_SCHK,
    S_SSQ,
    S_LEN,
    S_RHS,
    S_CMP,
    S_OUT
  } state_e;

  // product selected for the multiply-accumulate unit
  typedef enum logic [2:0] {
    OP_NONE,
    OP_R2,   // radius * radius
    OP_SC,   // plane component * centre coordinate
    OP_SD,   // plane offset * 1.0
    OP_SS,   // |s| * |s|
    OP_CC,   // plane component squared
    OP_LR    // len^2 * r^2
  } op_e;

  typedef enum logic [2:0] {
    SAVE_NONE,
    SAVE_R2,
    SAVE_S,
    SAVE_LHS,
    SAVE_LEN
  } save_e;

  typedef struct packed {
    logic       load;
    logic       latch;
    logic       pln_load;
    logic [2:0] plane;
    op_e        op;
    logic [1:0] k;
    logic [1:0] di;
    logic       clr;
    save_e      save;
  } sfc_cmd_t;

  typedef struct packed {
    logic degen;
    logic s_neg;
    logic gt;
  } sfc_sts_t;

  // index of the last multiplier digit for each product
  function automatic logic [1:0] dig_last(op_e op);
    logic [1:0] r;
    unique case (op)
      OP_SD:        r = 2'd0;
      OP_R2,
      OP_SC,
      OP_CC:        r = 2'd1;
      OP_SS,
      OP_LR:        r = 2'd3;
      default:      r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sfc_dp.sv =====
// ----------------------------------------------------------------------------
// sfc_dp
// Matrix store, plane extraction and shared 68x17 multiply-accumulate unit.
// ----------------------------------------------------------------------------
module sfc_dp import sfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfc_cmd_t           cmd_i,
  input  logic [1:0]         column_index_i,
  input  logic signed [31:0] col_x_i,
  input  logic signed [31:0] col_y_i,
  input  logic signed [31:0] col_z_i,
  input  logic signed [31:0] col_w_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output sfc_sts_t           sts_o
);

  localparam logic [OPA_W-1:0] D_SCALE = OPA_W'(65536);

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n : v;
  endfunction

  logic [31:0]        m_q [4][4];   // [column][row]
  logic signed [31:0] ctr_q [3];
  logic [30:0]        rad_q;
  logic signed [32:0] comp_q [4];
  logic signed [32:0] comp_d [4];
  logic [67:0]        s_q;
  logic [135:0]       lhs_q;
  logic [67:0]        len_q;
  logic [61:0]        r2_q;
  logic [ACC_W-1:0]   p_q, p_d;

  // matrix store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          m_q[c][r] <= '0;
        end
      end
    end else if (cmd_i.load) begin
      m_q[column_index_i][0] <= col_x_i;
      m_q[column_index_i][1] <= col_y_i;
      m_q[column_index_i][2] <= col_z_i;
      m_q[column_index_i][3] <= col_w_i;
    end
  end

  // plane components: row 3 plus or minus row 0, 1 or 2
  always_comb begin
    logic signed [32:0] w;
    logic signed [32:0] e;
    for (int k = 0; k < 4; k++) begin
      w = 33'(signed'(m_q[k][3]));
      unique case (cmd_i.plane[2:1])
        2'd0:    e = 33'(signed'(m_q[k][0]));
        2'd1:    e = 33'(signed'(m_q[k][1]));
        default: e = 33'(signed'(m_q[k][2]));
      endcase
      comp_d[k] = cmd_i.plane[0] ? (w - e) : (w + e);
    end
  end

  assign sts_o.degen = (comp_d[0] == '0) && (comp_d[1] == '0) && (comp_d[2] == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ctr_q[0] <= center_x_i;
      ctr_q[1] <= center_y_i;
      ctr_q[2] <= center_z_i;
      rad_q    <= radius_i;
    end
    if (cmd_i.pln_load) begin
      for (int k = 0; k < 4; k++) begin
        comp_q[k] <= comp_d[k];
      end
    end
  end

  // operand selection
  logic signed [32:0] comp_k, ctr_k;
  logic [OPA_W-1:0]   a_op, b_op;
  logic               neg;

  always_comb begin
    unique case (cmd_i.k)
      2'd0:    begin comp_k = comp_q[0]; ctr_k = 33'(ctr_q[0]); end
      2'd1:    begin comp_k = comp_q[1]; ctr_k = 33'(ctr_q[1]); end
      2'd2:    begin comp_k = comp_q[2]; ctr_k = 33'(ctr_q[2]); end
      default: begin comp_k = comp_q[3]; ctr_k = 33'(ctr_q[2]); end
    endcase
  end

  always_comb begin
    a_op = '0;
    b_op = '0;
    neg  = 1'b0;
    unique case (cmd_i.op)
      OP_R2: begin
        a_op = OPA_W'(rad_q);
        b_op = OPA_W'(rad_q);
      end
      OP_SC: begin
        a_op = OPA_W'(mag33(comp_k));
        b_op = OPA_W'(mag33(ctr_k));
        neg  = comp_k[32] ^ ctr_k[32];
      end
      OP_SD: begin
        a_op = OPA_W'(mag33(comp_q[3]));
        b_op = D_SCALE;
        neg  = comp_q[3][32];
      end
      OP_SS: begin
        a_op = s_q;
        b_op = s_q;
      end
      OP_CC: begin
        a_op = OPA_W'(mag33(comp_k));
        b_op = OPA_W'(mag33(comp_k));
      end
      OP_LR: begin
        // len^2 is still in the accumulator on the first digit cycle
        a_op = cmd_i.clr ? p_q[67:0] : len_q;
        b_op = OPA_W'(r2_q);
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  // one digit of B per cycle, shifted into place and added to the accumulator
  logic [DIG_W-1:0]       dig;
  logic [5:0]             shamt;
  logic [OPA_W+DIG_W-1:0] prod;
  logic [ACC_W-1:0]       term, addend, base;

  always_comb begin
    unique case (cmd_i.di)
      2'd0:    begin dig = b_op[16:0];  shamt = 6'd0;  end
      2'd1:    begin dig = b_op[33:17]; shamt = 6'd17; end
      2'd2:    begin dig = b_op[50:34]; shamt = 6'd34; end
      default: begin dig = b_op[67:51]; shamt = 6'd51; end
    endcase
    prod   = (OPA_W+DIG_W)'(a_op) * (OPA_W+DIG_W)'(dig);
    term   = ACC_W'(prod) << shamt;
    addend = neg ? (~term + ACC_W'(1)) : term;
    base   = cmd_i.clr ? '0 : p_q;
    p_d    = base + addend;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      p_q <= p_d;
    end
  end

  logic [ACC_W-1:0] p_negv;
  assign p_negv = ~p_q + ACC_W'(1);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.save)
      SAVE_R2:  r2_q  <= p_q[61:0];
      SAVE_S:   s_q   <= p_q[ACC_W-1] ? p_negv[67:0] : p_q[67:0];
      SAVE_LHS: lhs_q <= p_q[135:0];
      SAVE_LEN: len_q <= p_q[67:0];
      default:  ;
    endcase
  end

  assign sts_o.s_neg = p_q[ACC_W-1];
  assign sts_o.gt    = lhs_q > p_q[135:0];

endmodule

// ===== hdl/sfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: walks the six planes and drives the multiply-accumulate unit.
// ----------------------------------------------------------------------------
module sfc_ctrl import sfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     kind_i,
  input  sfc_sts_t sts_i,
  output sfc_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o,
  output logic     visible_o
);

  state_e     state_q, state_d;
  logic [2:0] plane_q, plane_d;
  logic [1:0] k_q, k_d;
  logic [1:0] di_q, di_d;
  logic       vis_q, vis_d;
  op_e        op;
  logic       last_dig, last_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plane_q <= '0;
      k_q     <= '0;
      di_q    <= '0;
      vis_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      k_q     <= k_d;
      di_q    <= di_d;
      vis_q   <= vis_d;
    end
  end

  always_comb begin
    unique case (state_q)
      S_R2:    op = OP_R2;
      S_SDOT:  op = (k_q == 2'd3) ? OP_SD : OP_SC;
      S_SSQ:   op = OP_SS;
      S_LEN:   op = OP_CC;
      S_RHS:   op = OP_LR;
      default: op = OP_NONE;
    endcase
    last_dig = di_q == dig_last(op);
    unique case (state_q)
      S_SDOT:  last_term = k_q == 2'd3;
      S_LEN:   last_term = k_q == 2'd2;
      default: last_term = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    k_d     = k_q;
    di_d    = di_q;
    vis_d   = vis_q;

    cmd_o          = '0;
    cmd_o.op       = op;
    cmd_o.save     = SAVE_NONE;
    cmd_o.plane    = plane_q;
    cmd_o.k        = k_q;
    cmd_o.di       = di_q;
    cmd_o.clr      = (k_q == 2'd0) && (di_q == 2'd0);

    // digit and term stepping in the product states
    if (op != OP_NONE) begin
      if (last_dig) begin
        di_d = '0;
        k_d  = last_term ? 2'd0 : k_q + 2'd1;
      end else begin
        di_d = di_q + 2'd1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load  = !kind_i;
          cmd_o.latch = kind_i;
          if (kind_i) begin
            state_d = S_R2;
            plane_d = '0;
            k_d     = '0;
            di_d    = '0;
          end
        end
      end
      S_R2: begin
        if (last_dig) state_d = S_PLN;
      end
      S_PLN: begin
        cmd_o.pln_load = 1'b1;
        if (plane_q == 3'd0) cmd_o.save = SAVE_R2;
        if (sts_i.degen) begin
          if (plane_q == PLANE_LAST) begin
            vis_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            plane_d = plane_q + 3'd1;
          end
        end else begin
          state_d = S_SDOT;
        end
      end
      S_SDOT: begin
        if (last_dig && last_term) state_d = S_SCHK;
      end
      S_SCHK: begin
        cmd_o.save = SAVE_S;
        if (sts_i.s_neg) begin
          state_d = S_SSQ;
        end else if (plane_q == PLANE_LAST) begin
          vis_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          plane_d = plane_q + 3'd1;
          state_d = S_PLN;
        end
      end
      S_SSQ: begin
        if (last_dig) state_d = S_LEN;
      end
      S_LEN: begin
        if (cmd_o.clr) cmd_o.save = SAVE_LHS;
        if (last_dig && last_term) state_d = S_RHS;
      end
      S_RHS: begin
        if (cmd_o.clr) cmd_o.save = SAVE_LEN;
        if (last_dig) state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.gt) begin
          vis_d   = 1'b0;
          state_d = S_OUT;
        end else if (plane_q == PLANE_LAST) begin
          vis_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          plane_d = plane_q + 3'd1;
          state_d = S_PLN;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o    = state_q != S_IDLE;
  assign done_o    = state_q == S_OUT;
  assign visible_o = vis_q;

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> state_q == S_IDLE)
    else $error("result strobe not followed by idle");

  a_plane_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plane_q <= PLANE_LAST)
    else $error("plane counter out of range");

  a_test_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && kind_i) |=> state_q == S_R2)
    else $error("sphere test transfer not started");

  a_dig_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op != OP_NONE |-> di_q <= dig_last(op))
    else $error("digit counter past last digit");

endmodule

// ===== hdl/sphere_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Bounding-sphere versus view-frustum visibility test in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a rising edge with start_i high and busy_o low.
//   kind_i = 0 writes one column of the 4x4 matrix (column_index_i, col_*_i);
//   it gives no result and busy_o stays low.
//   kind_i = 1 tests a sphere (center_*_i, radius_i). busy_o rises, and the
//   answer appears on visible_o for one cycle with done_o high; the receiver
//   cannot stall and must take it in that cycle.
//   Each of the six planes is skipped when degenerate, ends after the dot
//   product when the centre is on the inner side, and otherwise needs the
//   full exact square compare; all products go through one shared
//   68x17-bit multiply-accumulate unit taking one 17-bit digit per cycle.
//   A new item is taken the cycle after done_o.
//   Reset clears the matrix to zero (every plane degenerate, so visible)
//   and returns the controller to idle.
// ----------------------------------------------------------------------------
module sphere_frustum_cull import sfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               kind_i,
  input  logic [1:0]         column_index_i,
  input  logic signed [31:0] col_x_i,
  input  logic signed [31:0] col_y_i,
  input  logic signed [31:0] col_z_i,
  input  logic signed [31:0] col_w_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output logic               done_o,
  output logic               visible_o
);

  sfc_cmd_t cmd;
  sfc_sts_t sts;

  sfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .kind_i    (kind_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .visible_o (visible_o)
  );

  sfc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .column_index_i (column_index_i),
    .col_x_i        (col_x_i),
    .col_y_i        (col_y_i),
    .col_z_i        (col_z_i),
    .col_w_i        (col_w_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .center_z_i     (center_z_i),
    .radius_i       (radius_i),
    .sts_o          (sts)
  );

endmodule

// ===== verif/tb_sphere_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// tb_sphere_frustum_cull
// Self-checking bench: loads matrices, tests spheres, checks visible_o
// against an exact wide-integer visibility predictor.
// ----------------------------------------------------------------------------
module tb_sphere_frustum_cull;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_TEST = 1'b1;
  localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               kind_i;
  logic [1:0]         column_index_i;
  logic signed [31:0] col_x_i, col_y_i, col_z_i, col_w_i;
  logic signed [31:0] center_x_i, center_y_i, center_z_i;
  logic [30:0]        radius_i;
  logic               done_o;
  logic               visible_o;

  sphere_frustum_cull dut (.*);

  logic [31:0]     mtx [16];
  bit              vis_q[$];
  int unsigned     err_cnt;
  int unsigned     res_cnt;
  int unsigned     vis_cnt;
  int unsigned     item_cnt;
  longint unsigned cyc;
  bit              idle_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cyc);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // exact plane test; 256-bit signed math is wide enough for all operands
  function automatic bit sphere_visible(logic signed [31:0] cx, logic signed [31:0] cy,
                                        logic signed [31:0] cz, logic [30:0] r);
    logic signed [255:0] comp [4];
    logic signed [255:0] s, len2, lhs, rhs, rr;
    int row;
    for (int p = 0; p < 6; p++) begin
      row = p >> 1;
      for (int k = 0; k < 4; k++) begin
        if ((p & 1) == 0)
          comp[k] = $signed(mtx[k*4+3]) + $signed(mtx[k*4+row]);
        else
          comp[k] = $signed(mtx[k*4+3]) - $signed(mtx[k*4+row]);
      end
      if (comp[0] == 0 && comp[1] == 0 && comp[2] == 0) continue;
      s = comp[0] * cx + comp[1] * cy + comp[2] * cz + comp[3] * 65536;
      if (s >= 0) continue;
      lhs = s * s;
      len2 = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
      rr = {225'd0, r};
      rhs = rr * rr * len2;
      if (lhs > rhs) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      res_cnt++;
      if (visible_o) vis_cnt++;
      if (vis_q.size() == 0) report("result with nothing expected");
      else begin
        bit want;
        want = vis_q.pop_front();
        if (visible_o !== want)
          report($sformatf("visible got %b want %b", visible_o, want));
      end
    end
  end

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
  endtask

  // one transfer; inputs change on the falling edge
  task automatic send_item(bit kind, logic [1:0] ci, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [30:0] r);
    idle_gap();
    start_i = 1'b1;
    kind_i = kind;
    column_index_i = ci;
    col_x_i = a; col_y_i = b; col_z_i = c; col_w_i = d;
    center_x_i = x; center_y_i = y; center_z_i = z; radius_i = r;
    do @(posedge clk_i); while (busy_o);
    item_cnt++;
    if (kind == KIND_LOAD) begin
      mtx[ci*4+0] = a; mtx[ci*4+1] = b; mtx[ci*4+2] = c; mtx[ci*4+3] = d;
    end else
      vis_q = {vis_q, sphere_visible(x, y, z, r)};
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic load_col(logic [1:0] ci, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic [31:0] d);
    send_item(KIND_LOAD, ci, a, b, c, d, $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  task automatic test_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r);
    send_item(KIND_TEST, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
              x, y, z, r);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rnd_rad();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_empty_matrix();
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    test_sphere(32'h7fff_ffff, 32'd0, 32'h8000_0000, 31'h7fff_ffff);
  endtask

  task automatic test_directed();
    // identity matrix: a unit frustum
    for (int c = 0; c < 4; c++)
      load_col(2'(c), c == 0 ? 32'h1_0000 : 0, c == 1 ? 32'h1_0000 : 0,
               c == 2 ? 32'h1_0000 : 0, c == 3 ? 32'h1_0000 : 0);
    test_sphere(0, 0, 0, 31'd0);
    test_sphere(32'h3_0000, 0, 0, 31'd0);             // outside, zero radius
    test_sphere(32'h3_0000, 0, 0, 31'h3_0000);         // big radius rescues it
    test_sphere(32'h2_0000, 0, 0, 31'h1_0000);         // touching: exact tie
    test_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    // degenerate planes: only w row
    for (int c = 0; c < 4; c++) load_col(2'(c), 0, 0, 0, c == 3 ? 32'h8000_0000 : 0);
    test_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd0);
    // extreme entries
    for (int c = 0; c < 4; c++)
      load_col(2'(c), 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    test_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
  endtask

  task automatic test_random(int unsigned n, bit gaps);
    idle_on = gaps;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        load_col(2'($urandom), rnd_val(), rnd_val(), rnd_val(), rnd_val());
      else
        test_sphere(rnd_val(), rnd_val(), rnd_val(), rnd_rad());
    end
  endtask

  task automatic test_full_frustum(int unsigned n);
    // a freshly loaded full matrix, then a batch of spheres against it
    for (int i = 0; i < n; i++) begin
      if (i % 12 == 0)
        for (int c = 0; c < 4; c++)
          load_col(2'(c), rnd_val(), rnd_val(), rnd_val(), rnd_val());
      test_sphere($urandom, $urandom, $urandom, 31'($urandom_range(0, 1 << 24)));
    end
  endtask

  initial begin
    err_cnt = 0; res_cnt = 0; vis_cnt = 0; item_cnt = 0; cyc = 0; idle_on = 1'b0;
    foreach (mtx[i]) mtx[i] = '0;
    rst_ni = 1'b0;
    start_i = 1'b0; kind_i = 1'b0; column_index_i = '0;
    col_x_i = '0; col_y_i = '0; col_z_i = '0; col_w_i = '0;
    center_x_i = '0; center_y_i = '0; center_z_i = '0; radius_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_matrix();
    test_directed();
    test_random(600, 1'b1);
    idle_on = 1'b1;
    test_full_frustum(340);
    test_random(280, 1'b0);

    while (vis_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("%0d items sent, %0d results checked (%0d visible, %0d culled)",
             item_cnt, res_cnt, vis_cnt, res_cnt - vis_cnt);
    if (err_cnt == 0) $display("Regression PASS");
    else begin
      $display("%0d mismatches", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sfc_pkg.sv
hdl/sfc_dp.sv
hdl/sfc_ctrl.sv
hdl/sphere_frustum_cull.sv
verif/tb_sphere_frustum_cull.sv
